[design/peg_pkg.sv]
// Shared types and constants for the piano envelope generator.
package peg_pkg;

    // Field widths
    localparam int TIME_W  = 24;
    localparam int SLOPE_W = 31;
    localparam int GAIN_W  = 32;
    localparam int FRAC_W  = 30;
    localparam int IDX_W   = 3;
    localparam int CFG_W   = 31;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;
    localparam logic signed [GAIN_W-1:0] GAIN_ONE = 32'sh4000_0000;

    // Pedal timing in samples
    localparam logic [TIME_W-1:0] PEDAL_HOLD_SAMPLES   = 24'd1440000;
    localparam logic [TIME_W-1:0] PEDAL_REWIND_SAMPLES = 24'd14400;

    // Register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_ATTACK_SAMPLES  = 3'd0,
        REG_ATTACK_SLOPE    = 3'd1,
        REG_RELEASE_SAMPLES = 3'd2,
        REG_RELEASE_SLOPE   = 3'd3,
        REG_DURATION        = 3'd4,
        REG_DECAY_START     = 3'd5,
        REG_DECAY_STEP      = 3'd6,
        REG_PEDAL_DECAY     = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [TIME_W-1:0]  attack_samples;
        logic [SLOPE_W-1:0] attack_slope;
        logic [TIME_W-1:0]  release_samples;
        logic [SLOPE_W-1:0] release_slope;
        logic [TIME_W-1:0]  duration_samples;
        logic [TIME_W-1:0]  decay_start_samples;
        logic [SLOPE_W-1:0] decay_step;
        logic [SLOPE_W-1:0] pedal_decay_step;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        attack_samples:      24'd480,
        attack_slope:        31'd2236962,
        release_samples:     24'd48,
        release_slope:       31'd22369621,
        duration_samples:    24'd4800,
        decay_start_samples: 24'd48000,
        decay_step:          31'd5592,
        pedal_decay_step:    31'd447
    };

    // Which envelope segment sets the gain
    typedef enum logic [1:0] {
        SEG_FLAT    = 2'd0,
        SEG_ATTACK  = 2'd1,
        SEG_RELEASE = 2'd2,
        SEG_DECAY   = 2'd3
    } seg_t;

    // Step strobes from the sequencer to the envelope unit
    typedef struct packed {
        logic load;   // item accepted: start and pedal handling
        logic mul;    // segment select and ramp multiply
        logic gain;   // gain resolve and time advance
    } gain_ctl_t;

endpackage

[design/peg_gain.sv]
// Envelope state and gain computation for the piano envelope generator.
module peg_gain (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  peg_pkg::gain_ctl_t                  ctl,
    input  logic                                start_req,
    input  logic                                pedal_held,
    input  peg_pkg::cfg_t                       cfg,
    output logic signed [peg_pkg::GAIN_W-1:0]   gain,
    output logic                                active
);

    localparam int TW = peg_pkg::TIME_W;
    localparam int GW = peg_pkg::GAIN_W;
    localparam int PW = peg_pkg::TIME_W + peg_pkg::SLOPE_W;

    logic [TW-1:0]          elapsed_reg, elapsed_next;
    logic [TW-1:0]          dur_reg, dur_next;
    logic                   latched_reg, latched_next;
    logic signed [GW-1:0]   last_gain_reg, last_gain_next;
    logic [peg_pkg::SLOPE_W-1:0] decay_reg;
    logic [PW-1:0]          prod_reg;
    peg_pkg::seg_t          seg_reg, seg_next;
    logic                   ended_reg;
    logic signed [GW-1:0]   gain_reg, gain_val;
    logic                   active_reg;

    logic [TW-1:0]          dur_start, el_start;
    logic [TW:0]            t_plus_rel;
    logic                   in_att, in_rel, in_dec, before_end;
    logic [TW-1:0]          mul_a;
    logic [peg_pkg::SLOPE_W-1:0] mul_b;
    logic signed [GW-1:0]   decay_s;

    // Start and pedal handling at item load
    always_comb begin
        dur_start    = start_req ? cfg.duration_samples : dur_reg;
        el_start     = start_req ? '0 : elapsed_reg;
        dur_next     = dur_start;
        elapsed_next = el_start;
        latched_next = latched_reg;
        if (pedal_held) begin
            dur_next     = peg_pkg::PEDAL_HOLD_SAMPLES;
            latched_next = 1'b1;
        end else if (latched_reg) begin
            // rewind to shortly before the end, floor at zero
            elapsed_next = (dur_start < peg_pkg::PEDAL_REWIND_SAMPLES) ? '0 :
                           dur_start - peg_pkg::PEDAL_REWIND_SAMPLES;
            latched_next = 1'b0;
        end
    end

    // Segment select and ramp operands
    always_comb begin
        t_plus_rel = {1'b0, elapsed_reg} + {1'b0, cfg.release_samples};
        before_end = elapsed_reg < dur_reg;
        in_att     = elapsed_reg < cfg.attack_samples;
        in_rel     = (t_plus_rel > {1'b0, dur_reg}) && before_end;
        in_dec     = (elapsed_reg > cfg.decay_start_samples) && before_end;
        if (in_att)      seg_next = peg_pkg::SEG_ATTACK;
        else if (in_rel) seg_next = peg_pkg::SEG_RELEASE;
        else if (in_dec) seg_next = peg_pkg::SEG_DECAY;
        else             seg_next = peg_pkg::SEG_FLAT;
        // release offset is below release_samples, so it fits the time width
        mul_a = in_att ? elapsed_reg : TW'(t_plus_rel - {1'b0, dur_reg});
        mul_b = in_att ? cfg.attack_slope : cfg.release_slope;
    end

    // Gain resolve
    always_comb begin
        decay_s = GW'($signed({1'b0, decay_reg}));
        case (seg_reg)
            peg_pkg::SEG_ATTACK: begin
                gain_val = (prod_reg > PW'(peg_pkg::GAIN_ONE)) ? peg_pkg::GAIN_ONE :
                           $signed(GW'(prod_reg));
            end
            peg_pkg::SEG_RELEASE: begin
                gain_val = (prod_reg >= PW'(peg_pkg::GAIN_ONE)) ? '0 :
                           peg_pkg::GAIN_ONE - $signed(GW'(prod_reg));
            end
            peg_pkg::SEG_DECAY: begin
                gain_val = last_gain_reg[GW-1] ? last_gain_reg + decay_s :
                           last_gain_reg - decay_s;
            end
            default: begin
                gain_val = peg_pkg::GAIN_ONE;
            end
        endcase
        last_gain_next = ended_reg ? last_gain_reg : gain_val;
    end

    // Envelope state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            elapsed_reg   <= '0;
            dur_reg       <= '0;
            latched_reg   <= 1'b0;
            last_gain_reg <= '0;
            active_reg    <= 1'b0;
        end else begin
            if (ctl.load) begin
                elapsed_reg <= elapsed_next;
                dur_reg     <= dur_next;
                latched_reg <= latched_next;
            end
            if (ctl.gain) begin
                last_gain_reg <= last_gain_next;
                active_reg    <= !ended_reg;
                if (!ended_reg && elapsed_reg != peg_pkg::TIME_MAX) begin
                    elapsed_reg <= elapsed_reg + 1'b1;
                end
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            decay_reg <= pedal_held ? cfg.pedal_decay_step : cfg.decay_step;
        end
        if (ctl.mul) begin
            prod_reg  <= PW'(mul_a) * PW'(mul_b);
            seg_reg   <= seg_next;
            ended_reg <= !before_end;
        end
        if (ctl.gain) begin
            gain_reg <= ended_reg ? '0 : gain_val;
        end
    end

    assign gain   = gain_reg;
    assign active = active_reg;

endmodule

[design/peg_lane.sv]
// One channel lane: sample times gain, shift and saturate.
module peg_lane #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                mul_en,
    input  logic signed [SAMPLE_BITS-1:0]       sample_in,
    input  logic signed [peg_pkg::GAIN_W-1:0]   gain,
    output logic signed [SAMPLE_BITS-1:0]       sample_out
);

    localparam int PW = SAMPLE_BITS + peg_pkg::GAIN_W;
    localparam int SW = PW - peg_pkg::FRAC_W;

    localparam logic signed [SW-1:0] SAT_HI = SW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

    logic signed [PW-1:0] prod_reg;
    logic signed [SW-1:0] shifted;

    // Registered product
    always_ff @(posedge aclk) begin
        if (mul_en) begin
            prod_reg <= PW'(sample_in) * PW'(gain);
        end
    end

    // Arithmetic shift then clip to the sample range
    always_comb begin
        shifted = prod_reg[PW-1:peg_pkg::FRAC_W];
        if (shifted > SAT_HI)      sample_out = SAT_HI[SAMPLE_BITS-1:0];
        else if (shifted < SAT_LO) sample_out = SAT_LO[SAMPLE_BITS-1:0];
        else                       sample_out = shifted[SAMPLE_BITS-1:0];
    end

endmodule

[design/piano_envelope_generator.sv]
// Piano envelope generator: top level with sequencer, lanes and output register.
// Each accepted item steps through ST_MUL, ST_GAIN, ST_SCALE and ST_OUT; the output load in ST_OUT raises m_tvalid.
// A new item is taken only in ST_IDLE, after the sequencer has stepped the last one through
// ramp multiply, gain resolve, lane multiply and output load.
// A full output register that is not taken stalls the last step.
// Reset (aresetn low, synchronous): registers back to defaults, envelope cleared, silent.
module piano_envelope_generator #(
    parameter int SAMPLE_BITS = 16,
    localparam int IN_W  = ((2 * SAMPLE_BITS + 2 + 7) / 8) * 8,
    localparam int OUT_W = ((2 * SAMPLE_BITS + 1 + 7) / 8) * 8
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // Input stream
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // [0] start_req, [1] pedal_held, then left_in, right_in, zero padded
    input  logic [IN_W-1:0]             s_tdata,
    // Result stream
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // left_out, right_out, active, zero padded
    output logic [OUT_W-1:0]            m_tdata,
    // Configuration writes
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [peg_pkg::IDX_W-1:0]   cfg_index,
    input  logic [peg_pkg::CFG_W-1:0]   cfg_data
);

    localparam int TW    = peg_pkg::TIME_W;
    localparam int LW    = SAMPLE_BITS;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_MUL   = 5'b00010,
        ST_GAIN  = 5'b00100,
        ST_SCALE = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    peg_pkg::cfg_t cfg_reg;
    peg_pkg::gain_ctl_t ctl;

    logic                   in_fire, out_load;
    logic signed [LW-1:0]   sample_reg [2];
    logic signed [LW-1:0]   lane_out [2];
    logic signed [peg_pkg::GAIN_W-1:0] gain;
    logic                   active;
    logic                   m_valid_reg;
    logic [OUT_W-1:0]       m_data_reg;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign out_load  = (state_reg == ST_OUT) && (!m_valid_reg || m_tready);
    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= peg_pkg::CFG_RESET;
        end else if (cfg_valid) begin
            case (peg_pkg::cfg_idx_t'(cfg_index))
                peg_pkg::REG_ATTACK_SAMPLES:  cfg_reg.attack_samples      <= cfg_data[TW-1:0];
                peg_pkg::REG_ATTACK_SLOPE:    cfg_reg.attack_slope        <= cfg_data;
                peg_pkg::REG_RELEASE_SAMPLES: cfg_reg.release_samples     <= cfg_data[TW-1:0];
                peg_pkg::REG_RELEASE_SLOPE:   cfg_reg.release_slope       <= cfg_data;
                peg_pkg::REG_DURATION:        cfg_reg.duration_samples    <= cfg_data[TW-1:0];
                peg_pkg::REG_DECAY_START:     cfg_reg.decay_start_samples <= cfg_data[TW-1:0];
                peg_pkg::REG_DECAY_STEP:      cfg_reg.decay_step          <= cfg_data;
                peg_pkg::REG_PEDAL_DECAY:     cfg_reg.pedal_decay_step    <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Item sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (in_fire) state_next = ST_MUL;
            ST_MUL:   state_next = ST_GAIN;
            ST_GAIN:  state_next = ST_SCALE;
            ST_SCALE: state_next = ST_OUT;
            ST_OUT:   if (out_load) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign ctl.load = in_fire;
    assign ctl.mul  = (state_reg == ST_MUL);
    assign ctl.gain = (state_reg == ST_GAIN);

    // Sample capture
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            sample_reg[0] <= s_tdata[2 +: LW];
            sample_reg[1] <= s_tdata[2 + LW +: LW];
        end
    end

    peg_gain u_gain (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (ctl),
        .start_req  (s_tdata[0]),
        .pedal_held (s_tdata[1]),
        .cfg        (cfg_reg),
        .gain       (gain),
        .active     (active)
    );

    // Channel lanes
    for (genvar i = 0; i < 2; i++) begin : g_lane
        peg_lane #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_lane (
            .aclk       (aclk),
            .mul_en     (state_reg == ST_SCALE),
            .sample_in  (sample_reg[i]),
            .gain       (gain),
            .sample_out (lane_out[i])
        );
    end

    // Merge lanes into the output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= OUT_W'({active, lane_out[1], lane_out[0]});
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for the piano envelope generator stream block.
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_BITS = 16;
    localparam int IN_W        = ((2 + 2 * SAMPLE_BITS) + 7) / 8 * 8;
    localparam int OUT_W       = ((2 * SAMPLE_BITS + 1) + 7) / 8 * 8;
    localparam int IDLE_LIMIT  = 4000;
    localparam int SETTLE_GAP  = 6;
    localparam int DRAIN_WAIT  = 12;
    localparam int TIME_W      = peg_pkg::TIME_W;
    localparam int SLOPE_W     = peg_pkg::SLOPE_W;
    localparam int FRAC_W      = peg_pkg::FRAC_W;
    localparam int IDX_W       = peg_pkg::IDX_W;
    localparam int CFG_W       = peg_pkg::CFG_W;

    // One input item and one result item, as carried on the streams
    typedef struct packed {
        logic                   start;
        logic                   pedal;
        logic signed [15:0]     left;
        logic signed [15:0]     right;
    } sample_item_t;

    typedef struct packed {
        logic [15:0] left;
        logic [15:0] right;
        logic        active;
    } envelope_out_t;

    typedef enum logic [1:0] {
        OP_ITEM,
        OP_CFG,
        OP_SETTLE
    } op_kind_t;

    typedef struct packed {
        op_kind_t           kind;
        sample_item_t       item;
        peg_pkg::cfg_idx_t  idx;
        logic [CFG_W-1:0]   data;
    } stim_op_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_W-1:0]        s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_W-1:0]       m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [IDX_W-1:0]       cfg_index = '0;
    logic [CFG_W-1:0]       cfg_data = '0;

    // Stimulus and expectations
    stim_op_t       stim_q[$];
    envelope_out_t  due_samples[$];
    int             mismatches = 0;

    // Shadow registers and envelope state
    peg_pkg::cfg_t      env_regs = peg_pkg::CFG_RESET;
    logic [TIME_W-1:0]  note_time = '0;
    logic [TIME_W-1:0]  note_len = '0;
    longint             prev_gain = 0;
    logic               pedal_down = 1'b0;

    // Handshake flags from the sampling edge, used by the driver
    logic item_taken = 1'b0;
    logic cfg_taken = 1'b0;
    int   gap_left = 0;
    int   burst_left = 1;
    int   settle_cnt = 0;
    int   rx_left = 0;
    int   rx_mode = 0;
    int   idle_cnt = 0;

    piano_envelope_generator #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Shadow register write
    function automatic void write_shadow(peg_pkg::cfg_idx_t idx, logic [CFG_W-1:0] val);
        case (idx)
            peg_pkg::REG_ATTACK_SAMPLES:  env_regs.attack_samples      = val[TIME_W-1:0];
            peg_pkg::REG_ATTACK_SLOPE:    env_regs.attack_slope        = val[SLOPE_W-1:0];
            peg_pkg::REG_RELEASE_SAMPLES: env_regs.release_samples     = val[TIME_W-1:0];
            peg_pkg::REG_RELEASE_SLOPE:   env_regs.release_slope       = val[SLOPE_W-1:0];
            peg_pkg::REG_DURATION:        env_regs.duration_samples    = val[TIME_W-1:0];
            peg_pkg::REG_DECAY_START:     env_regs.decay_start_samples = val[TIME_W-1:0];
            peg_pkg::REG_DECAY_STEP:      env_regs.decay_step          = val[SLOPE_W-1:0];
            default:                      env_regs.pedal_decay_step    = val[SLOPE_W-1:0];
        endcase
    endfunction

    function automatic longint clamp_unit(longint g);
        if (g < 0)
            return 0;
        if (g > longint'(peg_pkg::GAIN_ONE))
            return longint'(peg_pkg::GAIN_ONE);
        return g;
    endfunction

    // Sample times Q1.30 gain, arithmetic shift, saturate to the sample range
    function automatic logic [15:0] scale_lane(logic signed [15:0] s, longint g);
        longint p;
        p = longint'(s) * g;
        p = p >>> FRAC_W;
        if (p > 32767)
            p = 32767;
        if (p < -32768)
            p = -32768;
        return p[15:0];
    endfunction

    // Advance the envelope by one sample and return the scaled pair
    function automatic envelope_out_t predict_envelope(sample_item_t it);
        envelope_out_t r;
        longint t, dur, rel_from, gain, decay, back;
        gain = longint'(peg_pkg::GAIN_ONE);
        decay = longint'(env_regs.decay_step);
        r = '0;
        if (it.start) begin
            note_time = '0;
            note_len = env_regs.duration_samples;
        end
        // pedal down stretches the note, pedal release rewinds near the end
        if (it.pedal) begin
            note_len = peg_pkg::PEDAL_HOLD_SAMPLES;
            decay = longint'(env_regs.pedal_decay_step);
            pedal_down = 1'b1;
        end else if (pedal_down) begin
            back = longint'(note_len) - longint'(peg_pkg::PEDAL_REWIND_SAMPLES);
            note_time = (back < 0) ? '0 : back[TIME_W-1:0];
            pedal_down = 1'b0;
        end
        t = longint'(note_time);
        dur = longint'(note_len);
        rel_from = dur - longint'(env_regs.release_samples);
        if (dur > 0) begin
            if (t < longint'(env_regs.attack_samples))
                gain = clamp_unit(t * longint'(env_regs.attack_slope));
            else if (t > rel_from && t < dur)
                gain = clamp_unit(longint'(peg_pkg::GAIN_ONE)
                                  - (t - rel_from) * longint'(env_regs.release_slope));
            else if (t > longint'(env_regs.decay_start_samples) && t < dur)
                gain = (prev_gain >= 0) ? prev_gain - decay : prev_gain + decay;
        end
        // note over: silence, state held
        if (t >= dur)
            return r;
        prev_gain = gain;
        r.left = scale_lane(it.left, gain);
        r.right = scale_lane(it.right, gain);
        r.active = 1'b1;
        if (note_time != peg_pkg::TIME_MAX)
            note_time = note_time + 1'b1;
        return r;
    endfunction

    function automatic logic signed [15:0] pick_sample();
        case ($urandom % 8)
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2:       return 16'sh0000;
            3:       return 16'shffff;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic push_item(logic start, logic pedal, logic signed [15:0] l,
                             logic signed [15:0] r);
        stim_op_t op;
        op = '0;
        op.kind = OP_ITEM;
        op.item.start = start;
        op.item.pedal = pedal;
        op.item.left = l;
        op.item.right = r;
        stim_q.push_back(op);
    endtask

    task automatic push_reg(peg_pkg::cfg_idx_t idx, logic [CFG_W-1:0] val);
        stim_op_t op;
        op = '0;
        op.kind = OP_CFG;
        op.idx = idx;
        op.data = val;
        stim_q.push_back(op);
    endtask

    task automatic push_settle();
        stim_op_t op;
        op = '0;
        op.kind = OP_SETTLE;
        stim_q.push_back(op);
    endtask

    // One register setting, then notes and noise with random content
    task automatic push_phase(peg_pkg::cfg_t c, int n_items);
        int made, len, p_from, p_to, i;
        logic use_pedal;
        push_reg(peg_pkg::REG_ATTACK_SAMPLES, CFG_W'(c.attack_samples));
        push_reg(peg_pkg::REG_ATTACK_SLOPE, CFG_W'(c.attack_slope));
        push_reg(peg_pkg::REG_RELEASE_SAMPLES, CFG_W'(c.release_samples));
        push_reg(peg_pkg::REG_RELEASE_SLOPE, CFG_W'(c.release_slope));
        push_reg(peg_pkg::REG_DURATION, CFG_W'(c.duration_samples));
        push_reg(peg_pkg::REG_DECAY_START, CFG_W'(c.decay_start_samples));
        push_reg(peg_pkg::REG_DECAY_STEP, CFG_W'(c.decay_step));
        push_reg(peg_pkg::REG_PEDAL_DECAY, CFG_W'(c.pedal_decay_step));
        made = 0;
        while (made < n_items) begin
            if (made > n_items / 2 && made < n_items / 2 + 8)
                push_settle();
            len = $urandom_range(4, 40);
            if ($urandom % 5 != 0) begin
                // a note: start, then an optional pedal window
                if (len > n_items - made)
                    len = n_items - made;
                use_pedal = ($urandom % 3 == 0);
                p_from = $urandom_range(0, len - 1);
                p_to = $urandom_range(p_from, len);
                for (i = 0; i < len; i++)
                    push_item(i == 0, use_pedal && i >= p_from && i < p_to,
                              pick_sample(), pick_sample());
            end else begin
                len = $urandom_range(2, 10);
                if (len > n_items - made)
                    len = n_items - made;
                for (i = 0; i < len; i++)
                    push_item($urandom % 8 == 0, $urandom % 4 == 0,
                              pick_sample(), pick_sample());
            end
            made += len;
        end
    endtask

    function automatic peg_pkg::cfg_t rand_setting();
        peg_pkg::cfg_t c;
        c.attack_samples      = TIME_W'($urandom_range(0, 40));
        c.attack_slope        = SLOPE_W'($urandom_range(0, 32'h4000_0000));
        c.release_samples     = TIME_W'($urandom_range(0, 40));
        c.release_slope       = SLOPE_W'($urandom_range(0, 32'h4000_0000));
        c.duration_samples    = TIME_W'($urandom_range(0, 60));
        c.decay_start_samples = TIME_W'($urandom_range(0, 40));
        c.decay_step          = SLOPE_W'($urandom_range(0, 32'h4000_0000));
        c.pedal_decay_step    = SLOPE_W'($urandom_range(0, 32'h0100_0000));
        return c;
    endfunction

    // Stimulus build, reset and end of run
    initial begin : main_proc
        peg_pkg::cfg_t c;

        // reset setting: silent before start, attack, pedal, rewind, restart
        push_item(1'b0, 1'b0, 16'sh7fff, 16'sh8000);
        push_item(1'b0, 1'b0, 16'shffff, 16'sh0001);
        push_item(1'b1, 1'b0, 16'sh7fff, 16'sh8000);
        push_item(1'b0, 1'b0, 16'sh8000, 16'sh7fff);
        push_item(1'b0, 1'b0, 16'shffff, 16'sh0000);
        push_item(1'b0, 1'b0, 16'sh7fff, 16'sh7fff);
        push_item(1'b0, 1'b1, 16'sh8000, 16'sh8000);
        push_item(1'b0, 1'b1, 16'sh1234, 16'shedcb);
        push_item(1'b0, 1'b0, 16'sh7fff, 16'sh8000);
        push_item(1'b0, 1'b0, 16'sh8000, 16'sh7fff);
        push_item(1'b0, 1'b0, 16'shffff, 16'sh0001);
        push_item(1'b1, 1'b1, 16'sh7fff, 16'sh8000);
        push_item(1'b1, 1'b0, 16'sh7fff, 16'sh8000);
        push_item(1'b0, 1'b0, 16'sh0000, 16'sh0000);
        push_item(1'b0, 1'b0, 16'sh8000, 16'shffff);

        // short notes reaching release, decay and note end
        c = '{24'd4, 31'h1000_0000, 24'd4, 31'h1000_0000, 24'd20, 24'd8,
              31'h0010_0000, 31'h0004_0000};
        push_phase(c, 60);
        // ramp overshoot and full-scale decay swing
        c = '{24'd8, 31'h4000_0000, 24'd3, 31'h4000_0000, 24'd16, 24'd0,
              31'h4000_0000, 31'h0};
        push_phase(c, 60);
        // all zero: empty notes, pedal-only sound
        c = '0;
        push_phase(c, 50);
        // all at maximum
        c = '{24'hffffff, 31'h4000_0000, 24'hffffff, 31'h4000_0000, 24'hffffff,
              24'hffffff, 31'h4000_0000, 31'h4000_0000};
        push_phase(c, 50);
        push_phase(rand_setting(), 60);
        push_phase(rand_setting(), 60);
        push_phase(rand_setting(), 60);
        push_phase(peg_pkg::CFG_RESET, 40);

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (stim_q.size() != 0 || s_tvalid || cfg_valid || due_samples.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (due_samples.size() != 0) begin
            mismatches++;
            $display("missing %0d result items", due_samples.size());
        end
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Driver: items in bursts with gaps, register writes only when idle
    always @(negedge aclk) begin : feed_proc
        stim_op_t op;
        logic     nxt_valid;
        logic     nxt_cfg;
        nxt_valid = s_tvalid;
        nxt_cfg = cfg_valid;
        if (aresetn) begin
            if (s_tvalid && item_taken)
                nxt_valid = 1'b0;
            if (cfg_valid && cfg_taken)
                nxt_cfg = 1'b0;
            if (!nxt_valid && !nxt_cfg) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                end else if (stim_q.size() != 0) begin
                    op = stim_q[0];
                    case (op.kind)
                        OP_ITEM: begin
                            void'(stim_q.pop_front());
                            nxt_valid = 1'b1;
                            s_tdata <= IN_W'({op.item.right, op.item.left,
                                              op.item.pedal, op.item.start});
                            if (burst_left <= 1) begin
                                burst_left <= ($urandom % 5 == 0) ? $urandom_range(30, 80)
                                                                  : $urandom_range(1, 10);
                                gap_left <= ($urandom % 4 == 0) ? 0 : $urandom_range(1, 12);
                            end else begin
                                burst_left <= burst_left - 1;
                            end
                        end
                        OP_CFG: begin
                            if (due_samples.size() == 0 && settle_cnt >= SETTLE_GAP) begin
                                void'(stim_q.pop_front());
                                nxt_cfg = 1'b1;
                                cfg_index <= op.idx;
                                cfg_data <= op.data;
                            end
                        end
                        default: begin
                            // hold off until every expected result is back
                            if (due_samples.size() == 0)
                                void'(stim_q.pop_front());
                        end
                    endcase
                end
            end
            if (due_samples.size() == 0 && !s_tvalid && !m_tvalid)
                settle_cnt <= settle_cnt + 1;
            else
                settle_cnt <= 0;
        end
        s_tvalid <= nxt_valid;
        cfg_valid <= nxt_cfg;
    end

    // Receiver stall pattern: always ready, coin flip, or mostly stalled
    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode <= $urandom_range(0, 2);
            rx_left <= $urandom_range(20, 200);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom % 2);
            default: m_tready <= ($urandom % 8 == 0);
        endcase
    end

    // Monitor: predict on input accept, compare on result accept
    always @(posedge aclk) begin : watch_proc
        envelope_out_t got;
        envelope_out_t want;
        sample_item_t  seen;
        item_taken <= aresetn && s_tvalid && s_tready;
        cfg_taken <= aresetn && cfg_valid && cfg_ready;
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                write_shadow(peg_pkg::cfg_idx_t'(cfg_index), cfg_data);
            if (s_tvalid && s_tready) begin
                seen.start = s_tdata[0];
                seen.pedal = s_tdata[1];
                seen.left = s_tdata[17:2];
                seen.right = s_tdata[33:18];
                due_samples.push_back(predict_envelope(seen));
            end
            if (m_tvalid && m_tready) begin
                got.left = m_tdata[15:0];
                got.right = m_tdata[31:16];
                got.active = m_tdata[32];
                if (due_samples.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: left %0d right %0d active %0b",
                                 $signed(got.left), $signed(got.right), got.active);
                end else begin
                    want = due_samples.pop_front();
                    if (got != want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: left %0d/%0d right %0d/%0d ",
                                      "active %0b/%0b (expected/actual)"},
                                     $signed(want.left), $signed(got.left),
                                     $signed(want.right), $signed(got.right),
                                     want.active, got.active);
                    end
                end
            end
        end
    end

    // Watchdog on cycles without any handshake on the input, result or configuration ports
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

endmodule

[sim.f]
design/peg_pkg.sv
design/peg_gain.sv
design/peg_lane.sv
design/piano_envelope_generator.sv
tb/sv/testbench.sv
